// File: hw/rtl/pfq_pkg.sv
// ----------------------------------------------------------------------------
// pfq_pkg
// Shared types, codes and sizes for the priority fifo queue and its cells.
// ----------------------------------------------------------------------------
package pfq_pkg;

	// queue sizing
	localparam int QUEUE_DEPTH = 64;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int OCC_W       = 7;

	// field widths
	localparam int MODE_W = 2;
	localparam int ID_W   = 16;
	localparam int PRI_W  = 4;
	localparam int ARR_W  = 32;
	localparam int STAT_W = 2;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_POP    = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	// one queued entry
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
		logic [ARR_W-1:0] arr;
	} entry_t;

	// request payload
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ID_W-1:0]   entry_id;
		logic [PRI_W-1:0]  entry_priority;
		logic [ARR_W-1:0]  entry_arrival;
	} req_t;

	// response payload
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   popped_id;
		logic [PRI_W-1:0]  popped_priority;
		logic [ARR_W-1:0]  popped_arrival;
		logic [OCC_W-1:0]  occupancy;
	} rsp_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic             cap;   // compare phase: latch match flags
		logic             prio;  // request is a priority insert
		logic             ins;   // apply phase: shift toward tail and insert
		logic             pop;   // apply phase: shift toward head
		logic [CNT_W-1:0] count; // entries held before the request
	} cell_ctrl_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_APPLY = 2'b10
	} state_t;

endpackage

// File: hw/rtl/pfq_cell.sv
// ----------------------------------------------------------------------------
// pfq_cell
// One queue position: holds an entry, compares it against a new request and
// shifts toward head or tail together with its neighbors.
// ----------------------------------------------------------------------------
module pfq_cell (
	input  logic                    clk,
	input  logic [pfq_pkg::CNT_W-1:0] cell_idx,
	input  pfq_pkg::cell_ctrl_t     ctrl,
	input  pfq_pkg::entry_t         cand,
	input  pfq_pkg::entry_t         ins_entry,
	input  pfq_pkg::entry_t         left_entry,
	input  pfq_pkg::entry_t         right_entry,
	input  logic                    found_in,
	output logic                    found_out,
	output pfq_pkg::entry_t         entry
);
	import pfq_pkg::*;

	entry_t entry_q;
	logic   mark_q;
	logic   occupied;
	logic   beat;

	// new entry must stand ahead of this one
	assign occupied = cell_idx < ctrl.count;
	assign beat = occupied &&
		((cand.pri > entry_q.pri) ||
		 ((cand.pri == entry_q.pri) && (cand.arr < entry_q.arr)));

	// insertion point search hands a flag down the row
	assign found_out = found_in | mark_q;
	assign entry     = entry_q;

	// match flag latched when the request is taken
	always_ff @(posedge clk) begin
		if (ctrl.cap) begin
			mark_q <= !occupied || (ctrl.prio && beat);
		end
	end

	// entry storage and neighbor shifts
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (found_in) begin
				entry_q <= left_entry;
			end else if (mark_q) begin
				entry_q <= ins_entry;
			end
		end else if (ctrl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

// File: hw/rtl/priority_fifo_queue_core.sv
// ----------------------------------------------------------------------------
// priority_fifo_queue_core
// Bounded ordered queue with tail append, priority insert and head pop,
// built as a row of shifting cells.
// ----------------------------------------------------------------------------
// a taken request is held in req_q; its compare phase checks every cell at
// once as it is taken, then the apply phase walks the insertion flag,
//   shifts the row and registers the response, taking no request meanwhile
// a waiting response does not hold off taking a request, but stalls its apply
// reset: asynchronous, clears the count, the sequencer and the response valid
// ----------------------------------------------------------------------------
module priority_fifo_queue_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pfq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pfq_pkg::rsp_t rsp
);
	import pfq_pkg::*;

	state_t           state_q;
	req_t             req_q;
	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             fire;
	logic             push_op;
	logic             pop_op;
	logic             full;
	logic             empty;
	logic             do_ins;
	logic             do_pop;
	rsp_t             rsp_d;
	cell_ctrl_t       ctrl;
	entry_t           cand;
	entry_t           ins_entry;
	entry_t           cell_entry [QUEUE_DEPTH];
	logic             found [QUEUE_DEPTH+1];

	// handshake
	assign req_stall = (state_q == ST_APPLY);
	assign accept    = req_valid && !req_stall;
	assign fire      = (state_q == ST_APPLY) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// decode of the held request
	assign push_op = (req_q.mode == MODE_APPEND) || (req_q.mode == MODE_INSERT);
	assign pop_op  = (req_q.mode == MODE_POP);
	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_ins  = fire && push_op && !full;
	assign do_pop  = fire && pop_op && !empty;

	// broadcast to the cells
	assign cand      = '{id: req.entry_id, pri: req.entry_priority, arr: req.entry_arrival};
	assign ins_entry = '{id: req_q.entry_id, pri: req_q.entry_priority,
	                     arr: req_q.entry_arrival};
	always_comb begin
		ctrl       = '0;
		ctrl.cap   = accept;
		ctrl.prio  = (req.mode == MODE_INSERT);
		ctrl.ins   = do_ins;
		ctrl.pop   = do_pop;
		ctrl.count = count_q;
	end

	// row of cells
	assign found[0] = 1'b0;
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		if (i == 0) begin : g_head
			assign left_e = '0;
		end else begin : g_mid_l
			assign left_e = cell_entry[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_mid_r
			assign right_e = cell_entry[i+1];
		end
		pfq_cell u_cell (
			.clk         (clk),
			.cell_idx    (CNT_W'(i)),
			.ctrl        (ctrl),
			.cand        (cand),
			.ins_entry   (ins_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.found_in    (found[i]),
			.found_out   (found[i+1]),
			.entry       (cell_entry[i])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (fire) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// held request
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (do_pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response built from the held request
	always_comb begin
		rsp_d = '0;
		if (push_op) begin
			rsp_d.status    = full ? STAT_FULL : STAT_DONE;
			rsp_d.occupancy = full ? OCC_W'(count_q) : OCC_W'(count_q + CNT_W'(1));
		end else if (pop_op) begin
			if (empty) begin
				rsp_d.status    = STAT_EMPTY;
				rsp_d.occupancy = '0;
			end else begin
				rsp_d.status          = STAT_DONE;
				rsp_d.popped_id       = cell_entry[0].id;
				rsp_d.popped_priority = cell_entry[0].pri;
				rsp_d.popped_arrival  = cell_entry[0].arr;
				rsp_d.occupancy       = OCC_W'(count_q - CNT_W'(1));
			end
		end else begin
			rsp_d.status    = STAT_DONE;
			rsp_d.occupancy = OCC_W'(count_q);
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// File: hw/rtl/pfq_checker.sv
// ----------------------------------------------------------------------------
// pfq_checker
// Port-level checks for the priority fifo queue, bound to the top level.
// ----------------------------------------------------------------------------
module pfq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input pfq_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input pfq_pkg::rsp_t rsp
);
	import pfq_pkg::*;

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// one request at a time: a taken request blocks the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous still in work");

	// occupancy never exceeds the depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.occupancy <= OCC_W'(QUEUE_DEPTH))
		else $error("occupancy beyond depth");

	// a refused pop reports an empty queue and no entry
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_EMPTY |->
			rsp.occupancy == '0 && rsp.popped_id == '0 &&
			rsp.popped_priority == '0 && rsp.popped_arrival == '0)
		else $error("refused pop with nonzero fields");

	// a refused push reports a full queue
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_FULL |->
			rsp.occupancy == OCC_W'(QUEUE_DEPTH) && rsp.popped_id == '0)
		else $error("refused push while not full");

endmodule

bind priority_fifo_queue_core pfq_checker u_pfq_checker (.*);

// File: verif/priority_fifo_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_fifo_queue_core_tb
// Drives tail appends, priority inserts, head pops and the unused mode into
// the queue core. A scoreboard keeps its own ordered copy of the queue,
// predicts each response and compares it field by field. Both handshakes
// idle at random, with one stretch of full rate.
// ----------------------------------------------------------------------------
module priority_fifo_queue_core_tb;
	import pfq_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int STALL_PCT   = 36;
	localparam int RANDOM_REQS = 1830;
	localparam int QUIET_LIMIT = 2000;
	localparam int REPORT_MAX  = 10;

	// ordered copy of the queue and the responses it implies
	class queue_scoreboard;
		entry_t waiting[$];
		rsp_t   expected_rsp[$];
		int     errors;
		int     checked;

		function int pending();
			return expected_rsp.size();
		endfunction

		// apply one accepted request to the queue copy
		function void note_request(req_t r);
			rsp_t   res;
			entry_t fresh;
			int     pos;
			res = '0;
			fresh.id  = r.entry_id;
			fresh.pri = r.entry_priority;
			fresh.arr = r.entry_arrival;
			case (r.mode)
				MODE_APPEND, MODE_INSERT: begin
					if (waiting.size() >= QUEUE_DEPTH) begin
						res.status = STAT_FULL;
					end else begin
						pos = waiting.size();
						// walk from the head, stop at the first entry to precede
						if (r.mode == MODE_INSERT) begin
							for (int i = 0; i < waiting.size(); i++) begin
								if (fresh.pri > waiting[i].pri ||
								    (fresh.pri == waiting[i].pri && fresh.arr < waiting[i].arr)) begin
									pos = i;
									break;
								end
							end
						end
						waiting.insert(pos, fresh);
						res.status = STAT_DONE;
					end
				end
				MODE_POP: begin
					if (waiting.size() == 0) begin
						res.status = STAT_EMPTY;
					end else begin
						fresh = waiting.pop_front();
						res.status          = STAT_DONE;
						res.popped_id       = fresh.id;
						res.popped_priority = fresh.pri;
						res.popped_arrival  = fresh.arr;
					end
				end
				default: res.status = STAT_DONE;
			endcase
			res.occupancy = OCC_W'(waiting.size());
			expected_rsp.push_back(res);
		endfunction

		// compare one accepted response with the oldest prediction
		function void check_response(rsp_t got);
			rsp_t want;
			checked++;
			if (expected_rsp.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("response %0d arrived with no request outstanding", checked);
				return;
			end
			want = expected_rsp.pop_front();
			if (got.status !== want.status || got.popped_id !== want.popped_id ||
			    got.popped_priority !== want.popped_priority ||
			    got.popped_arrival !== want.popped_arrival ||
			    got.occupancy !== want.occupancy) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("mismatch on response %0d", checked);
					$display("  expected status %0d id %h pri %0d arr %h occ %0d",
						want.status, want.popped_id, want.popped_priority,
						want.popped_arrival, want.occupancy);
					$display("  actual   status %0d id %h pri %0d arr %h occ %0d",
						got.status, got.popped_id, got.popped_priority,
						got.popped_arrival, got.occupancy);
				end
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	bit   calm      = 1'b0;
	int   quiet_cycles = 0;

	queue_scoreboard sb = new();

	priority_fifo_queue_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// response back-pressure
	always @(negedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < STALL_PCT);
	end

	// handshake monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	function automatic req_t build_request(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
		logic [PRI_W-1:0] pri, logic [ARR_W-1:0] arr);
		req_t r;
		r.mode           = mode;
		r.entry_id       = id;
		r.entry_priority = pri;
		r.entry_arrival  = arr;
		return r;
	endfunction

	// random fields, clustered so priority and arrival ties are common
	function automatic req_t random_request(logic [MODE_W-1:0] mode);
		req_t r;
		r.mode = mode;
		if ($urandom_range(3) == 0)
			r.entry_id = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		else
			r.entry_id = 16'($urandom);
		if ($urandom_range(2) == 0)
			r.entry_priority = 4'($urandom_range(9, 6));
		else
			r.entry_priority = 4'($urandom);
		case ($urandom_range(9))
			0:       r.entry_arrival = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
			1, 2, 3: r.entry_arrival = 32'($urandom_range(7));
			default: r.entry_arrival = $urandom;
		endcase
		return r;
	endfunction

	// present one request from a falling edge until it is taken
	task automatic issue_request(req_t r);
		if (!calm) begin
			while ($urandom_range(99) < STALL_PCT) begin
				req_valid <= 1'b0;
				@(negedge clk);
			end
		end
		req       <= r;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (req_stall);
		@(negedge clk);
	endtask

	// stop sending until every predicted response has come back
	task automatic hold_until_drained();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic run_directed();
		// pop on empty queue
		issue_request(build_request(MODE_POP, 16'h0, 4'h0, 32'h0));
		// field extremes appended at the tail
		issue_request(build_request(MODE_APPEND, 16'hFFFF, 4'hF, 32'hFFFF_FFFF));
		issue_request(build_request(MODE_APPEND, 16'h0000, 4'h0, 32'h0));
		// equal priority, earlier arrival goes to the head
		issue_request(build_request(MODE_INSERT, 16'h1111, 4'hF, 32'h0));
		// equal priority and equal arrival stays behind
		issue_request(build_request(MODE_INSERT, 16'h2222, 4'hF, 32'h0));
		// lowest priority, latest arrival lands at the tail
		issue_request(build_request(MODE_INSERT, 16'h3333, 4'h0, 32'hFFFF_FFFF));
		// plain append leaves the queue unsorted
		issue_request(build_request(MODE_APPEND, 16'h4444, 4'hF, 32'h5));
		// insert stops at the first lower entry, not the sorted spot
		issue_request(build_request(MODE_INSERT, 16'h5555, 4'h8, 32'h100));
		issue_request(build_request(MODE_INSERT, 16'h6666, 4'h0, 32'h0));
		// unused mode leaves the queue alone
		issue_request(build_request(MODE_UNUSED, 16'hABCD, 4'h9, 32'h1234_5678));
		// drain all eight entries, then one pop too many
		repeat (9)
			issue_request(build_request(MODE_POP, 16'($urandom), 4'($urandom), $urandom));
		issue_request(build_request(MODE_INSERT, 16'hAAAA, 4'h7, 32'h1234_5678));
		issue_request(build_request(MODE_POP, 16'h0, 4'h0, 32'h0));
	endtask

	// bursts that lean toward filling or draining the queue, or keep it balanced
	task automatic run_random();
		int               sent;
		int               phase_left;
		int               push_pct;
		int               pick;
		logic [MODE_W-1:0] mode;
		sent       = 0;
		phase_left = 0;
		push_pct   = 55;
		while (sent < RANDOM_REQS) begin
			if (phase_left <= 0) begin
				phase_left = $urandom_range(150, 20);
				case ($urandom_range(2))
					0:       push_pct = 85;
					1:       push_pct = 15;
					default: push_pct = 55;
				endcase
			end
			calm = (sent >= 600 && sent < 900);
			if (sent == 1200)
				hold_until_drained();
			pick = $urandom_range(99);
			if (pick < push_pct)
				mode = ($urandom_range(99) < 60) ? MODE_INSERT : MODE_APPEND;
			else if (pick < 98)
				mode = MODE_POP;
			else
				mode = MODE_UNUSED;
			issue_request(random_request(mode));
			if (mode != MODE_UNUSED)
				sent++;
			phase_left--;
		end
		calm = 1'b0;
	endtask

	// reset, stimulus and final verdict
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		run_random();
		hold_until_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/pfq_pkg.sv
hw/rtl/pfq_cell.sv
hw/rtl/priority_fifo_queue_core.sv
hw/rtl/pfq_checker.sv
verif/priority_fifo_queue_core_tb.sv
